FILE: hw/rtl/pcr_pkg.sv
package pcr_pkg;

  localparam int PATH_BYTES_DEF = 1024;

  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic ACT_PATH = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic KIND_REPORT = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // one input word plus the flags the front attaches
  typedef struct packed {
    logic       action;
    logic       target;
    logic [7:0] char_in;
    logic       first_char;
    logic       last_char;
    logic [9:0] read_index;
    logic       is_slash;
    logic       is_dot;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  read_char;
    logic [10:0] path_length;
    logic        overflow;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_READ_OUT,
    S_COPY,
    S_COPY_END,
    S_START,
    S_CHAR,
    S_PUT_SLASH,
    S_PUT_DOTS,
    S_PUT_CHAR,
    S_BACK_RD,
    S_BACK_CHK,
    S_LAST,
    S_REPORT
  } state_t;

endpackage

FILE: hw/rtl/pcr_front.sv
module pcr_front
  import pcr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       action,
  input  logic       target,
  input  logic [7:0] char_in,
  input  logic       first_char,
  input  logic       last_char,
  input  logic [9:0] read_index,
  output logic       item_valid,
  output item_t      item,
  input  logic       item_pop
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  item_t      in_item;
  logic       do_push;
  logic       do_pop;

  // classify the incoming word
  always_comb begin
    in_item.action     = action;
    in_item.target     = target;
    in_item.char_in    = char_in;
    in_item.first_char = first_char;
    in_item.last_char  = last_char;
    in_item.read_index = read_index;
    in_item.is_slash   = (char_in == CH_SLASH);
    in_item.is_dot     = (char_in == CH_DOT);
  end

  assign full       = (count == 2'd2);
  assign item_valid = (count != 2'd0);
  assign item       = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = item_pop && item_valid;

  // hold queued words
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= in_item;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: hw/rtl/pcr_outq.sv
module pcr_outq
  import pcr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    res_push,
  input  result_t res,
  output logic    res_full,
  output logic    empty,
  input  logic    pop,
  output result_t head
);

  result_t    slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign head     = slots[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // hold waiting results
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= res;
    end
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

FILE: hw/rtl/pcr_back.sv
module pcr_back
  import pcr_pkg::*;
#(
  parameter int PATH_BYTES = PATH_BYTES_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  input  item_t   item,
  output logic    item_pop,
  output logic    res_push,
  output result_t res,
  input  logic    res_full
);

  localparam int AW = $clog2(PATH_BYTES);
  localparam int LW = AW + 1;
  localparam int CW = (LW > 10) ? LW : 10;
  localparam int OW = (LW > 11) ? LW : 11;

  logic [7:0] cur_mem [PATH_BYTES];
  logic [7:0] scr_mem [PATH_BYTES];
  logic [7:0] cur_q;
  logic [7:0] scr_q;

  state_t        state, state_next;
  item_t         it, it_next;
  logic [LW-1:0] cur_len, cur_len_next;
  logic [LW-1:0] scr_len, scr_len_next;
  logic [1:0]    count, count_next;
  logic          all_dots, all_dots_next;
  logic          abs_mode, abs_mode_next;
  logic          ovf, ovf_next;
  logic          fin, fin_next;
  logic [LW-1:0] cnt, cnt_next;
  logic [1:0]    dots_left, dots_left_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_addr, pend_addr_next;

  logic [LW-1:0] len_sel;
  logic [LW-1:0] len_m1;
  logic [LW-1:0] lsel_next;
  logic          len_wr;
  logic [7:0]    rsel_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          do_put;
  logic [7:0]    put_data;
  logic          cur_we;
  logic          scr_we;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [CW-1:0] idx_w;
  logic [CW-1:0] len_w;
  logic [OW-1:0] len_o;

  assign len_sel = it.target ? scr_len : cur_len;
  assign len_m1  = len_sel - LW'(1);
  assign rsel_q  = it.target ? scr_q : cur_q;
  assign idx_w   = CW'(it.read_index);
  assign len_w   = CW'(len_sel);
  assign len_o   = OW'(len_sel);

  // route the single write port: copy writes and path writes never overlap
  assign scr_we  = pend || (do_put && it.target);
  assign cur_we  = do_put && !it.target;
  assign wr_addr = pend ? pend_addr : len_sel[AW-1:0];
  assign wr_data = pend ? cur_q : put_data;

  // store memories with registered read
  always_ff @(posedge clk) begin
    if (cur_we) begin
      cur_mem[wr_addr] <= wr_data;
    end
    if (scr_we) begin
      scr_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      cur_q <= cur_mem[rd_addr];
      scr_q <= scr_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cur_len  <= '0;
      scr_len  <= '0;
      count    <= 2'd0;
      all_dots <= 1'b1;
      abs_mode <= 1'b0;
      ovf      <= 1'b0;
      pend     <= 1'b0;
    end else begin
      state    <= state_next;
      cur_len  <= cur_len_next;
      scr_len  <= scr_len_next;
      count    <= count_next;
      all_dots <= all_dots_next;
      abs_mode <= abs_mode_next;
      ovf      <= ovf_next;
      pend     <= pend_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    it        <= it_next;
    fin       <= fin_next;
    cnt       <= cnt_next;
    dots_left <= dots_left_next;
    pend_addr <= pend_addr_next;
  end

  // sequence one word at a time
  always_comb begin
    state_next     = state;
    it_next        = it;
    cur_len_next   = cur_len;
    scr_len_next   = scr_len;
    count_next     = count;
    all_dots_next  = all_dots;
    abs_mode_next  = abs_mode;
    ovf_next       = ovf;
    fin_next       = fin;
    cnt_next       = cnt;
    dots_left_next = dots_left;
    pend_next      = 1'b0;
    pend_addr_next = cnt[AW-1:0];
    lsel_next      = len_sel;
    len_wr         = 1'b0;
    item_pop       = 1'b0;
    res_push       = 1'b0;
    res            = '0;
    rd_en          = 1'b0;
    rd_addr        = len_m1[AW-1:0];
    do_put         = 1'b0;
    put_data       = it.char_in;

    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          it_next  = item;
          cnt_next = '0;
          if (item.action == ACT_READ) begin
            state_next = S_READ;
          end else if (item.first_char) begin
            ovf_next   = 1'b0;
            state_next = item.target ? S_COPY : S_START;
          end else begin
            state_next = S_CHAR;
          end
        end
      end
      S_READ: begin
        rd_en      = 1'b1;
        rd_addr    = idx_w[AW-1:0];
        state_next = S_READ_OUT;
      end
      S_READ_OUT: begin
        res_push        = 1'b1;
        res.kind        = KIND_READ;
        res.read_char   = (idx_w < len_w) ? rsel_q : 8'd0;
        res.path_length = len_o[10:0];
        res.overflow    = ovf;
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      S_COPY: begin
        // walk the current store into the scratch store
        if (cnt < cur_len) begin
          rd_en     = 1'b1;
          rd_addr   = cnt[AW-1:0];
          pend_next = 1'b1;
          cnt_next  = cnt + LW'(1);
        end else begin
          state_next = S_COPY_END;
        end
      end
      S_COPY_END: begin
        scr_len_next = cur_len;
        state_next   = S_START;
      end
      S_START: begin
        abs_mode_next = it.is_slash;
        if (it.is_slash) begin
          lsel_next = '0;
          len_wr    = 1'b1;
        end
        count_next    = 2'd0;
        all_dots_next = 1'b1;
        state_next    = S_CHAR;
      end
      S_CHAR: begin
        fin_next = 1'b0;
        priority if (abs_mode) begin
          do_put     = 1'b1;
          state_next = S_LAST;
        end else if (it.is_slash) begin
          if (all_dots && count == 2'd2) begin
            state_next = S_BACK_RD;
          end else begin
            count_next    = 2'd0;
            all_dots_next = 1'b1;
            state_next    = S_LAST;
          end
        end else if (all_dots && it.is_dot && count < 2'd2) begin
          count_next = count + 2'd1;
          state_next = S_LAST;
        end else if (all_dots) begin
          dots_left_next = count;
          all_dots_next  = 1'b0;
          count_next     = 2'd0;
          state_next     = S_PUT_SLASH;
        end else begin
          do_put     = 1'b1;
          state_next = S_LAST;
        end
      end
      S_PUT_SLASH: begin
        do_put     = 1'b1;
        put_data   = CH_SLASH;
        state_next = (dots_left != 2'd0) ? S_PUT_DOTS : S_PUT_CHAR;
      end
      S_PUT_DOTS: begin
        do_put         = 1'b1;
        put_data       = CH_DOT;
        dots_left_next = dots_left - 2'd1;
        if (dots_left == 2'd1) begin
          state_next = S_PUT_CHAR;
        end
      end
      S_PUT_CHAR: begin
        do_put     = 1'b1;
        state_next = S_LAST;
      end
      S_BACK_RD: begin
        // drop one stored character, stop at the root
        if (len_sel == '0) begin
          count_next    = 2'd0;
          all_dots_next = 1'b1;
          state_next    = fin ? S_REPORT : S_LAST;
        end else begin
          rd_en      = 1'b1;
          lsel_next  = len_m1;
          len_wr     = 1'b1;
          state_next = S_BACK_CHK;
        end
      end
      S_BACK_CHK: begin
        if (rsel_q == CH_SLASH) begin
          count_next    = 2'd0;
          all_dots_next = 1'b1;
          state_next    = fin ? S_REPORT : S_LAST;
        end else begin
          state_next = S_BACK_RD;
        end
      end
      S_LAST: begin
        if (!it.last_char) begin
          state_next = S_IDLE;
        end else if (!abs_mode && all_dots && count == 2'd2) begin
          fin_next   = 1'b1;
          state_next = S_BACK_RD;
        end else begin
          if (!abs_mode) begin
            count_next    = 2'd0;
            all_dots_next = 1'b1;
          end
          state_next = S_REPORT;
        end
      end
      S_REPORT: begin
        res_push        = 1'b1;
        res.kind        = KIND_REPORT;
        res.read_char   = 8'd0;
        res.path_length = len_o[10:0];
        res.overflow    = ovf;
        if (!res_full) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // append one character, saturating at capacity
    if (do_put) begin
      if (len_sel < LW'(PATH_BYTES)) begin
        lsel_next = len_sel + LW'(1);
        len_wr    = 1'b1;
      end else begin
        do_put   = 1'b0;
        ovf_next = 1'b1;
      end
    end

    if (len_wr) begin
      if (it.target) begin
        scr_len_next = lsel_next;
      end else begin
        cur_len_next = lsel_next;
      end
    end
  end

`ifndef SYNTHESIS
  a_cur_len_cap: assert property (@(posedge clk) disable iff (rst)
    cur_len <= LW'(PATH_BYTES))
    else $error("current length past capacity");

  a_scr_len_cap: assert property (@(posedge clk) disable iff (rst)
    scr_len <= LW'(PATH_BYTES))
    else $error("scratch length past capacity");

  a_push_state: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (state == S_REPORT || state == S_READ_OUT))
    else $error("result pushed outside an output state");

  a_pop_busy: assert property (@(posedge clk) disable iff (rst)
    item_pop |=> state != S_IDLE)
    else $error("word taken but engine stayed idle");

  a_copy_no_put: assert property (@(posedge clk) disable iff (rst)
    pend |-> !do_put)
    else $error("copy write collided with a path write");
`endif

endmodule

FILE: hw/rtl/path_component_resolver_top.sv
// Path component resolver.
// Input channel: push/full queue. Each word is a path character (action 0)
// for the current directory store (target 0) or the scratch store (target 1),
// or a read of a stored character (action 1). first_char and last_char frame
// a path; a first character on target 1 loads the scratch store from the
// current directory.
// Result channel: empty/pop queue. A path's last character yields a report
// (kind 0) with the new length and the overflow flag; a read yields kind 1.
// The engine walks its stores through one read and one write address, so
// removing a component for '..' steps back one stored character at a time
// and loading the scratch store copies the current store character by
// character. A two-word input queue and a two-word result queue decouple
// the engine from both sides. Reset clears both lengths, the component
// state and the queues; store contents are not cleared. When the receiver
// holds pop low, results wait in the result queue, then the engine stalls,
// then the input queue fills.
module path_component_resolver_top
  import pcr_pkg::*;
#(
  parameter int PATH_BYTES = PATH_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        action,
  input  logic        target,
  input  logic [7:0]  char_in,
  input  logic        first_char,
  input  logic        last_char,
  input  logic [9:0]  read_index,
  output logic        empty,
  input  logic        pop,
  output logic        kind,
  output logic [7:0]  read_char,
  output logic [10:0] path_length,
  output logic        overflow
);

  logic    item_valid;
  item_t   item;
  logic    item_pop;
  logic    res_push;
  result_t res;
  logic    res_full;
  result_t head;

  pcr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .target     (target),
    .char_in    (char_in),
    .first_char (first_char),
    .last_char  (last_char),
    .read_index (read_index),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  pcr_back #(
    .PATH_BYTES (PATH_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_push   (res_push),
    .res        (res),
    .res_full   (res_full)
  );

  pcr_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign kind        = head.kind;
  assign read_char   = head.read_char;
  assign path_length = head.path_length;
  assign overflow    = head.overflow;

endmodule

FILE: tb/tb_path_component_resolver_top.sv
module tb_path_component_resolver_top;
  import pcr_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int RANDOM_PATHS = 38;
  localparam int CYCLE_LIMIT  = 4000000;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic        action;
  logic        target;
  logic [7:0]  char_in;
  logic        first_char;
  logic        last_char;
  logic [9:0]  read_index;
  logic        empty;
  logic        pop;
  logic        kind;
  logic [7:0]  read_char;
  logic [10:0] path_length;
  logic        overflow;

  path_component_resolver_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .action(action), .target(target), .char_in(char_in),
    .first_char(first_char), .last_char(last_char), .read_index(read_index),
    .empty(empty), .pop(pop), .kind(kind), .read_char(read_char),
    .path_length(path_length), .overflow(overflow)
  );

  // directed word with an optional hand-written expectation
  typedef struct {
    logic       act;
    logic       tgt;
    logic [7:0] ch;
    logic       first;
    logic       last;
    logic [9:0] idx;
    bit         typed;
    result_t    res;
  } dir_word_t;

  // resolver image: two stores and the component state
  logic [7:0] store [2][DEPTH];
  int         store_len [2];
  int         dot_count;
  bit         all_dots;
  bit         abs_mode;
  bit         drop_flag;

  result_t    expected_words[$];
  dir_word_t  dir_words[$];
  int         fails;
  int         cycles;
  int         words_sent;
  int         reads_sent;
  int         paths_sent;
  int         results_seen;
  int         overflow_reports;
  bit         burst;
  bit         hold_req;

  // clock and cycle limit
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_path_component_resolver_top: FAIL");
      $finish;
    end
  end

  // store write that saturates at capacity
  function automatic void put_byte(int t, logic [7:0] c);
    if (store_len[t] < DEPTH) begin
      store[t][store_len[t]] = c;
      store_len[t]++;
    end else begin
      drop_flag = 1'b1;
    end
  endfunction

  // close a component, backing up one level on a dot-dot
  function automatic void close_component(int t);
    if (all_dots && dot_count == 2) begin
      while (store_len[t] > 0) begin
        store_len[t]--;
        if (store[t][store_len[t]] == CH_SLASH) break;
      end
    end
    dot_count = 0;
    all_dots  = 1'b1;
  endfunction

  function automatic void name_byte(int t, logic [7:0] c);
    if (all_dots && c == CH_DOT && dot_count < 2) begin
      dot_count++;
      return;
    end
    if (all_dots) begin
      put_byte(t, CH_SLASH);
      for (int i = 0; i < dot_count; i++) put_byte(t, CH_DOT);
      all_dots  = 1'b0;
      dot_count = 0;
    end
    put_byte(t, c);
  endfunction

  // advance the resolver image by one word
  function automatic bit resolve_word(logic act, logic tgt, logic [7:0] c, logic first,
                                      logic last, logic [9:0] idx, output result_t r);
    int t;
    t = tgt;
    r = '0;
    if (act == ACT_READ) begin
      r.kind        = KIND_READ;
      r.read_char   = (idx < store_len[t]) ? store[t][idx] : 8'h00;
      r.path_length = 11'(store_len[t]);
      r.overflow    = drop_flag;
      return 1'b1;
    end
    if (first) begin
      drop_flag = 1'b0;
      if (tgt) begin
        for (int i = 0; i < store_len[0]; i++) store[1][i] = store[0][i];
        store_len[1] = store_len[0];
      end
      abs_mode = (c == CH_SLASH);
      if (abs_mode) store_len[t] = 0;
      dot_count = 0;
      all_dots  = 1'b1;
    end
    if (abs_mode) put_byte(t, c);
    else if (c == CH_SLASH) close_component(t);
    else name_byte(t, c);
    if (!last) return 1'b0;
    if (!abs_mode) close_component(t);
    r.kind        = KIND_REPORT;
    r.path_length = 11'(store_len[t]);
    r.overflow    = drop_flag;
    return 1'b1;
  endfunction

  function automatic int idle_draw();
    return burst ? 0 : $urandom_range(0, 18);
  endfunction

  // offer one word, hold it until accepted, then log what it should produce
  task automatic send_word(logic act, logic tgt, logic [7:0] c, logic first, logic last,
                           logic [9:0] idx, bit typed, result_t typed_res);
    int      gap;
    bit      has;
    result_t r;
    gap = idle_draw();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    action     <= act;
    target     <= tgt;
    char_in    <= c;
    first_char <= first;
    last_char  <= last;
    read_index <= idx;
    do @(posedge clk); while (full);
    has = resolve_word(act, tgt, c, first, last, idx, r);
    if (has) expected_words.push_back(typed ? typed_res : r);
    words_sent++;
    if (act == ACT_READ) reads_sent++;
    if (first && act == ACT_PATH) paths_sent++;
  endtask

  task automatic send_plain(logic act, logic tgt, logic [7:0] c, logic first, logic last,
                            logic [9:0] idx);
    send_word(act, tgt, c, first, last, idx, 1'b0, '0);
  endtask

  task automatic add_row(logic act, logic tgt, logic [7:0] c, logic first, logic last,
                         logic [9:0] idx, bit typed, logic k, logic [7:0] rc,
                         logic [10:0] len, logic ov);
    dir_word_t w;
    w.act = act; w.tgt = tgt; w.ch = c; w.first = first; w.last = last; w.idx = idx;
    w.typed = typed;
    w.res.kind = k; w.res.read_char = rc; w.res.path_length = len; w.res.overflow = ov;
    dir_words.push_back(w);
  endtask

  // random name byte, never a slash
  function automatic logic [7:0] name_char();
    logic [7:0] c;
    case ($urandom_range(0, 3))
      0: c = CH_DOT;
      1: c = 8'h61 + 8'($urandom_range(0, 5));
      default: c = 8'($urandom_range(0, 255));
    endcase
    if (c == CH_SLASH) c = 8'h00;
    return c;
  endfunction

  // build a well-formed path from random components
  task automatic build_path(output logic [7:0] q[$]);
    int n;
    q = {};
    if ($urandom_range(0, 2) == 0) q.push_back(CH_SLASH);
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      if (i > 0 || $urandom_range(0, 3) == 0) q.push_back(CH_SLASH);
      case ($urandom_range(0, 5))
        0: q.push_back(CH_DOT);
        1: begin q.push_back(CH_DOT); q.push_back(CH_DOT); end
        2: ;
        default: repeat ($urandom_range(1, 4)) q.push_back(name_char());
      endcase
    end
    if ($urandom_range(0, 4) == 0) q.push_back(CH_SLASH);
    if (q.size() == 0) q.push_back(name_char());
  endtask

  task automatic send_path(logic tgt, logic [7:0] q[$]);
    foreach (q[i]) send_plain(ACT_PATH, tgt, q[i], i == 0, i == q.size() - 1, '0);
  endtask

  task automatic random_read();
    logic t;
    int   hi;
    t  = $urandom_range(0, 1);
    hi = (store_len[t] + 4 > DEPTH - 1) ? DEPTH - 1 : store_len[t] + 4;
    send_plain(ACT_READ, t, 8'($urandom), $urandom_range(0, 1), $urandom_range(0, 1),
               ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, hi)));
  endtask

  // receiver: draw a stall per word, take results, compare field by field
  initial begin
    int      w;
    result_t e;
    pop = 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        pop <= 1'b0;
        repeat (1200) @(posedge clk);
        hold_req = 1'b0;
      end
      w = idle_draw();
      if (w > 0) begin
        pop <= 1'b0;
        repeat (w) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      results_seen++;
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected: kind %0d len %0d", kind, path_length);
        fails++;
      end else begin
        e = expected_words.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind); fails++;
        end
        if (read_char !== e.read_char) begin
          $error("read_char: expected %0h, got %0h", e.read_char, read_char); fails++;
        end
        if (path_length !== e.path_length) begin
          $error("path_length: expected %0d, got %0d", e.path_length, path_length); fails++;
        end
        if (overflow !== e.overflow) begin
          $error("overflow: expected %0d, got %0d", e.overflow, overflow); fails++;
        end
        if (e.kind == KIND_REPORT && e.overflow) overflow_reports++;
      end
    end
  end

  // sender: reset, directed table, random paths, drain
  initial begin
    logic [7:0] q[$];
    int         limit;
    rst = 1'b1; push = 1'b0; action = 1'b0; target = 1'b0; char_in = '0;
    first_char = 1'b0; last_char = 1'b0; read_index = '0;
    words_sent = 0; reads_sent = 0; paths_sent = 0;
    burst = 1'b0; hold_req = 1'b0;
    store_len[0] = 0; store_len[1] = 0;
    dot_count = 0; all_dots = 1'b1; abs_mode = 1'b0; drop_flag = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reads after reset, root, dot-dot at root, dots and empty components,
    // zero and high bytes, scratch copy, continuation, read past the end
    add_row(ACT_READ, 0, 8'h00, 0, 0, 10'd0,    1, KIND_READ, 8'h00, 11'd0, 0);
    add_row(ACT_READ, 1, 8'hFF, 1, 1, 10'd1023, 1, KIND_READ, 8'h00, 11'd0, 0);
    add_row(ACT_PATH, 0, CH_SLASH, 1, 1, 10'd0, 1, KIND_REPORT, 8'h00, 11'd1, 0);
    add_row(ACT_READ, 0, 8'h00, 0, 0, 10'd0,    1, KIND_READ, CH_SLASH, 11'd1, 0);
    add_row(ACT_PATH, 0, CH_DOT, 1, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_DOT, 0, 1, 10'd0,   1, KIND_REPORT, 8'h00, 11'd0, 0);
    add_row(ACT_PATH, 0, 8'h61, 1, 0, 10'd0,    0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_SLASH, 0, 0, 10'd0, 0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_SLASH, 0, 0, 10'd0, 0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_DOT, 0, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_SLASH, 0, 0, 10'd0, 0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_DOT, 0, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_DOT, 0, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_DOT, 0, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, 8'h62, 0, 1, 10'd0,    0, 0, 0, 0, 0);
    add_row(ACT_PATH, 1, 8'h00, 1, 1, 10'd0,    0, 0, 0, 0, 0);
    add_row(ACT_READ, 1, 8'h00, 0, 0, 10'd3,    0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, CH_DOT, 0, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 0, 8'h7A, 0, 1, 10'd0,    0, 0, 0, 0, 0);
    add_row(ACT_PATH, 1, CH_DOT, 1, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 1, CH_DOT, 0, 0, 10'd0,   0, 0, 0, 0, 0);
    add_row(ACT_PATH, 1, CH_SLASH, 0, 0, 10'd0, 0, 0, 0, 0, 0);
    add_row(ACT_PATH, 1, 8'hFF, 0, 1, 10'd0,    0, 0, 0, 0, 0);
    add_row(ACT_READ, 1, 8'h00, 0, 0, 10'd1023, 1, KIND_READ, 8'h00, 11'd9, 0);
    add_row(ACT_READ, 0, 8'h00, 0, 0, 10'd2,    0, 0, 0, 0, 0);
    foreach (dir_words[i])
      send_word(dir_words[i].act, dir_words[i].tgt, dir_words[i].ch, dir_words[i].first,
                dir_words[i].last, dir_words[i].idx, dir_words[i].typed, dir_words[i].res);

    // random paths with reads and noise mixed in
    for (int p = 0; p < RANDOM_PATHS; p++) begin
      burst = ($urandom_range(0, 9) == 0);
      if (p == 8) hold_req = 1'b1;
      if (p == 20) begin
        push <= 1'b0;
        do @(posedge clk); while (expected_words.size() != 0);
      end
      if (p == 12) begin
        // fill the current store past capacity, then overflow the scratch copy
        q = {CH_SLASH};
        repeat (DEPTH + 6) q.push_back(8'($urandom_range(0, 255)));
        send_path(0, q);
        send_plain(ACT_READ, 0, 8'h00, 0, 0, 10'd1023);
        send_path(1, '{8'h71});
        send_plain(ACT_READ, 1, 8'h00, 0, 0, 10'd1023);
      end
      case ($urandom_range(0, 9))
        0, 1: random_read();
        2: begin
          limit = $urandom_range(1, 3);
          repeat (limit)
            send_plain(ACT_PATH, $urandom_range(0, 1), 8'($urandom), $urandom_range(0, 1),
                       $urandom_range(0, 1), 10'($urandom));
        end
        default: ;
      endcase
      build_path(q);
      send_path($urandom_range(0, 1), q);
      if ($urandom_range(0, 1) == 0) random_read();
    end
    burst = 1'b0;
    push <= 1'b0;

    // drain and let the engine settle
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2200) @(posedge clk);
    $display("covered %0d words: %0d paths, %0d reads, %0d results checked",
             words_sent, paths_sent, reads_sent, results_seen);
    $display("reports with dropped characters: %0d, mismatches: %0d",
             overflow_reports, fails);
    if (fails == 0 && expected_words.size() == 0)
      $display("tb_path_component_resolver_top: PASS");
    else
      $display("tb_path_component_resolver_top: FAIL");
    $finish;
  end

endmodule
